// ----- src/sbsm_pkg.sv -----
`default_nettype none

package sbsm_pkg;

	// Bus command codes.
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Target memory codes.
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_PRG  = 2'd1;
	localparam logic [1:0] TGT_CHR  = 2'd2;
	localparam logic [1:0] TGT_RAM  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_INIT_MIRRORING = 2'd0;
	localparam logic [1:0] CFG_PRG_COUNT_LOG2 = 2'd1;
	localparam logic [1:0] CFG_CHR_COUNT_LOG2 = 2'd2;

	// Internal register select, taken from address bits 14..13 of a serial write.
	localparam logic [1:0] SEL_CONTROL  = 2'd0;
	localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
	localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
	localparam logic [1:0] SEL_PRG      = 2'd3;

	// Field widths.
	localparam int CMD_W    = 2;
	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int TGT_W    = 2;
	localparam int MIR_W    = 2;
	localparam int LOG2_W   = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 3;
	localparam int REG_W    = 5;
	localparam int HOLD_W   = 3;
	localparam int BANK_W   = 7;   // widest bank number after the count mask
	localparam int WIDE_W   = 21;  // bank number shifted by 14, before truncation

	// Reset values.
	localparam logic [REG_W-1:0]  SHIFT_EMPTY      = 5'h10;
	localparam logic [REG_W-1:0]  PRG_MODE3_BITS   = 5'h0C;
	localparam logic [MIR_W-1:0]  INIT_MIRRORING_RESET = 2'd0;
	localparam logic [LOG2_W-1:0] PRG_COUNT_LOG2_RESET = 3'd3;
	localparam logic [LOG2_W-1:0] CHR_COUNT_LOG2_RESET = 3'd1;

	// Parameter defaults.
	localparam int HOLDOFF_TICKS_DEFAULT = 6;
	localparam int OFFSET_BITS_DEFAULT   = 18;

	// PRG modes in control bits 3..2.
	localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

	// Mask for a bank count of 2**log2 banks.
	function automatic logic [BANK_W-1:0] bank_mask(input logic [LOG2_W-1:0] log2);
		bank_mask = ~({BANK_W{1'b1}} << log2);
	endfunction

endpackage

`default_nettype wire

// ----- src/serial_bank_switch_mapper.sv -----
`default_nettype none

// Serial bank-switching mapper. Each item is one bus read, one bus write or one
// clock tick, and each item gives exactly one result: the target memory, the byte
// offset in it, whether the access writes it, the current mirroring mode and
// whether a write completed a five-bit serial register load. The whole
// translation and state update is done in the cycle an item is accepted and the
// result sits in an output register, so the block takes one item per clock and
// delivers each result in the cycle after acceptance; in_stall rises only while
// that register holds a result the downstream side is stalling. Configuration
// registers must be written through cfg_we/cfg_index/cfg_data only while no
// item is in flight, not enforced by the block; initial_mirroring is accepted
// but, as the mirroring is loaded only at reset, it has no visible effect.
module serial_bank_switch_mapper
	import sbsm_pkg::*;
#(
	parameter int HOLDOFF_TICKS = HOLDOFF_TICKS_DEFAULT,
	parameter int OFFSET_BITS   = OFFSET_BITS_DEFAULT
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// Configuration port.
	input  wire                    cfg_we,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data,
	// Input channel.
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire [CMD_W-1:0]        command,
	input  wire [ADDR_W-1:0]       address,
	input  wire [DATA_W-1:0]       write_data,
	// Output channel.
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic [TGT_W-1:0]       target,
	output logic [OFFSET_BITS-1:0] mapped_offset,
	output logic                   memory_write,
	output logic [MIR_W-1:0]       mirroring_mode,
	output logic                   register_loaded
);

	localparam logic [HOLD_W-1:0] HOLD_LOAD = HOLD_W'(HOLDOFF_TICKS);

	logic [LOG2_W-1:0] prg_log2_q, chr_log2_q;
	logic [REG_W-1:0]  shift_q, control_q, chr_low_q, chr_high_q, prg_word_q;
	logic [HOLD_W-1:0] holdoff_q;

	logic [REG_W-1:0]  shift_d, control_d, chr_low_d, chr_high_d, prg_word_d;
	logic [HOLD_W-1:0] holdoff_d;

	logic              in_fire, out_fire;
	logic              out_valid_q;
	logic [TGT_W-1:0]  target_q, target_d;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [WIDE_W-1:0] offset_d;
	logic              mwrite_q, mwrite_d;
	logic [MIR_W-1:0]  mirror_q;
	logic              loaded_q, loaded_d;

	logic              is_read, is_write;
	logic [BANK_W-1:0] prg_last, chr_last, prg_sel, chr_sel;
	logic [1:0]        prg_mode;

	// Handshake: the output register frees up when its result is taken.
	assign out_fire = out_valid_q && !out_stall;
	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_log2_q <= PRG_COUNT_LOG2_RESET;
			chr_log2_q <= CHR_COUNT_LOG2_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRG_COUNT_LOG2: prg_log2_q <= cfg_data;
				CFG_CHR_COUNT_LOG2: chr_log2_q <= cfg_data;
				// The initial mirroring is only used at reset.
				CFG_INIT_MIRRORING: ;
				default: ;
			endcase
		end
	end

	assign is_read  = (command == CMD_READ);
	assign is_write = (command == CMD_WRITE);
	assign prg_mode = control_q[3:2];
	assign prg_last = bank_mask(prg_log2_q);
	assign chr_last = bank_mask(chr_log2_q);

	// PRG bank select for the window that the address falls in.
	always_comb begin
		logic [BANK_W-1:0] bank;
		bank = BANK_W'(prg_word_q[3:0]);
		if (prg_mode != PRG_MODE_FIX_FIRST && prg_mode != PRG_MODE_FIX_LAST) begin
			prg_sel = address[14] ? (bank | BANK_W'(1)) : (bank & ~BANK_W'(1));
		end else if (prg_mode == PRG_MODE_FIX_FIRST) begin
			prg_sel = address[14] ? bank : '0;
		end else begin
			prg_sel = address[14] ? prg_last : bank;
		end
		prg_sel = prg_sel & prg_last;
	end

	// CHR bank select: one 8K bank or two 4K banks.
	always_comb begin
		logic [BANK_W-1:0] low, high;
		low  = BANK_W'(chr_low_q);
		high = BANK_W'(chr_high_q);
		if (!control_q[4]) begin
			chr_sel = address[12] ? (low | BANK_W'(1)) : (low & ~BANK_W'(1));
		end else begin
			chr_sel = address[12] ? high : low;
		end
		chr_sel = chr_sel & chr_last;
	end

	// Address decode and serial register update for one item.
	always_comb begin
		shift_d    = shift_q;
		control_d  = control_q;
		chr_low_d  = chr_low_q;
		chr_high_d = chr_high_q;
		prg_word_d = prg_word_q;
		holdoff_d  = holdoff_q;
		target_d   = TGT_NONE;
		offset_d   = '0;
		mwrite_d   = 1'b0;
		loaded_d   = 1'b0;

		if (command == CMD_TICK) begin
			if (holdoff_q != '0) begin
				holdoff_d = holdoff_q - HOLD_W'(1);
			end
		end else if (is_read || is_write) begin
			if (address[15:13] == 3'b000) begin
				// Character memory window.
				target_d = TGT_CHR;
				offset_d = (WIDE_W'(chr_sel) << 12) | WIDE_W'(address[11:0]);
				mwrite_d = is_write;
			end else if (address[15:13] == 3'b011) begin
				// Program RAM, unless disabled by the PRG register.
				if (!prg_word_q[4]) begin
					target_d = TGT_RAM;
					offset_d = WIDE_W'(address[12:0]);
					mwrite_d = is_write;
				end
			end else if (address[15]) begin
				if (is_read) begin
					target_d = TGT_PRG;
					offset_d = (WIDE_W'(prg_sel) << 14) | WIDE_W'(address[13:0]);
				end else if (holdoff_q == '0) begin
					// Serial port write, LSB first.
					holdoff_d = HOLD_LOAD;
					if (write_data[7]) begin
						shift_d   = SHIFT_EMPTY;
						control_d = control_q | PRG_MODE3_BITS;
					end else begin
						shift_d = {write_data[0], shift_q[REG_W-1:1]};
						if (shift_q[0]) begin
							loaded_d = 1'b1;
							case (address[14:13])
								SEL_CONTROL:  control_d  = shift_d;
								SEL_CHR_LOW:  chr_low_d  = shift_d;
								SEL_CHR_HIGH: chr_high_d = shift_d;
								SEL_PRG:      prg_word_d = shift_d;
								default: ;
							endcase
							shift_d = SHIFT_EMPTY;
						end
					end
				end
			end
		end
	end

	// Mapper state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= SHIFT_EMPTY;
			control_q  <= PRG_MODE3_BITS | REG_W'(INIT_MIRRORING_RESET);
			chr_low_q  <= '0;
			chr_high_q <= '0;
			prg_word_q <= '0;
			holdoff_q  <= '0;
		end else if (in_fire) begin
			shift_q    <= shift_d;
			control_q  <= control_d;
			chr_low_q  <= chr_low_d;
			chr_high_q <= chr_high_d;
			prg_word_q <= prg_word_d;
			holdoff_q  <= holdoff_d;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			target_q <= target_d;
			offset_q <= offset_d[OFFSET_BITS-1:0];
			mwrite_q <= mwrite_d;
			mirror_q <= control_d[MIR_W-1:0];
			loaded_q <= loaded_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign target          = target_q;
	assign mapped_offset   = offset_q;
	assign memory_write    = mwrite_q;
	assign mirroring_mode  = mirror_q;
	assign register_loaded = loaded_q;

`ifndef SYNTH
	// A completed serial load never maps to a memory.
	a_loaded_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && register_loaded |-> target == TGT_NONE)
		else $error("register load reported with a target");

	// Only character memory and program RAM take writes.
	a_write_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && memory_write |-> (target == TGT_CHR || target == TGT_RAM))
		else $error("memory write to a read-only or absent target");

	// No target means a zero offset.
	a_none_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target == TGT_NONE |-> mapped_offset == '0)
		else $error("nonzero offset without a target");

	// An accepted tick counts the hold-off down by one.
	a_tick_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && command == CMD_TICK && holdoff_q != '0
		|=> holdoff_q == $past(holdoff_q) - HOLD_W'(1))
		else $error("hold-off did not count down on a tick");

	// A loaded register restarts the shift register at the sentinel.
	a_loaded_shift_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && loaded_d |=> shift_q == SHIFT_EMPTY)
		else $error("shift register not emptied after a load");
`endif

endmodule

`default_nettype wire
